FILE: rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg: postfix stack evaluator shared definitions
// Sizes, token and error codes, sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

	localparam int STACK_DEPTH  = 16;
	localparam int NUM_ARRAYS   = 4;
	localparam int ARRAY_LENGTH = 256;

	localparam int SP_W      = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W    = $clog2(STACK_DEPTH);
	localparam int MEM_DEPTH = NUM_ARRAYS * ARRAY_LENGTH;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	localparam logic [1:0] OPC_LIT   = 2'd0;
	localparam logic [1:0] OPC_REF   = 2'd1;
	localparam logic [1:0] OPC_APPLY = 2'd2;
	localparam logic [1:0] OPC_WRITE = 2'd3;

	localparam logic [4:0] OP_SUBSCRIPT = 5'd0;
	localparam logic [4:0] OP_MUL       = 5'd1;
	localparam logic [4:0] OP_DIV       = 5'd2;
	localparam logic [4:0] OP_REM       = 5'd3;
	localparam logic [4:0] OP_ADD       = 5'd4;
	localparam logic [4:0] OP_SUB       = 5'd5;
	localparam logic [4:0] OP_SHL       = 5'd6;
	localparam logic [4:0] OP_SHR       = 5'd7;
	localparam logic [4:0] OP_LT        = 5'd8;
	localparam logic [4:0] OP_LE        = 5'd9;
	localparam logic [4:0] OP_GT        = 5'd10;
	localparam logic [4:0] OP_GE        = 5'd11;
	localparam logic [4:0] OP_EQ        = 5'd12;
	localparam logic [4:0] OP_NE        = 5'd13;
	localparam logic [4:0] OP_AND       = 5'd14;
	localparam logic [4:0] OP_XOR       = 5'd15;
	localparam logic [4:0] OP_OR        = 5'd16;
	localparam logic [4:0] OP_LAND      = 5'd17;
	localparam logic [4:0] OP_LOR       = 5'd18;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_UNDER   = 3'd1;
	localparam logic [2:0] ERR_OVER    = 3'd2;
	localparam logic [2:0] ERR_DIVZERO = 3'd3;
	localparam logic [2:0] ERR_TYPE    = 3'd4;
	localparam logic [2:0] ERR_INDEX   = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_OPRD,
		ST_MEMRD,
		ST_DIV,
		ST_PUSH,
		ST_FIN,
		ST_LASTRD,
		ST_OUT
	} pse_state_t;

endpackage

`default_nettype wire

FILE: rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: token-serial postfix evaluator
// Operand stack, array memory, shared ALU and iterative divider under a
// small sequencer.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    opcode operator_code literal_value
//                                    array_id element_index first/last_token
// out      out  out_valid/out_stall  result_value error_code
//
// Push/array write: decode, finish. Operator: decode, operand read, memory
// read or divide if needed (one quotient bit per cycle in the shared
// divider), push, finish; rejected at decode: decode, finish. Last token
// adds a stack read (none on an empty stack), then waits until out is taken.
// in_stall is high except in idle. Reset clears stack pointer and error;
// stack and array contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator
	import pse_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic [4:0]         operator_code,
	input  wire logic signed [31:0] literal_value,
	input  wire logic [1:0]         array_id,
	input  wire logic [7:0]         element_index,
	input  wire logic               first_token,
	input  wire logic               last_token,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      result_value,
	output logic [2:0]              error_code
);

	pse_state_t state_q, state_d;

	logic [1:0]  opc_q;
	logic [4:0]  op_q;
	logic [31:0] lit_q;
	logic [1:0]  aid_q;
	logic [7:0]  eidx_q;
	logic        last_q;

	logic [SP_W-1:0] sp_q;
	logic [2:0]      err_q;

	logic [31:0] stk_val_q [STACK_DEPTH];
	logic        stk_ref_q [STACK_DEPTH];
	logic [31:0] rd_a_q, rd_b_q;
	logic        rd_ra_q, rd_rb_q;

	logic [31:0] mem_q [MEM_DEPTH];
	logic [31:0] mem_rd_q;

	logic [31:0] res_q;
	logic [31:0] out_val_q;

	logic [31:0] rem_q, quo_q, dvs_q;
	logic [4:0]  cnt_q;
	logic        neg_a_q, neg_b_q;

	logic [SIDX_W-1:0] idx_b, idx_a, idx_w;
	logic              sp_full, sp_lt2, op_bad;
	logic              sub_type_err, sub_idx_err, val_type_err, div_zero;
	logic              wr_ok;
	logic [MEM_AW-1:0] wr_addr, rd_addr;
	logic [31:0]       alu_res;
	logic              b_big;
	logic [32:0]       rem_sh, diff;
	logic [31:0]       rem_n, quo_n, div_res;
	logic [31:0]       mag_a, mag_b;
	logic [2:0]        err_last;

	assign idx_b   = SIDX_W'(sp_q - SP_W'(1));
	assign idx_a   = SIDX_W'(sp_q - SP_W'(2));
	assign idx_w   = SIDX_W'(sp_q);
	assign sp_full = (sp_q == SP_W'(STACK_DEPTH));
	assign sp_lt2  = (sp_q < SP_W'(2));
	assign op_bad  = (op_q > OP_LOR);

	assign sub_type_err = !rd_ra_q || rd_rb_q;
	assign sub_idx_err  = (rd_a_q >= 32'(NUM_ARRAYS)) || rd_b_q[31]
		|| (rd_b_q >= 32'(ARRAY_LENGTH));
	assign val_type_err = rd_ra_q || rd_rb_q;
	assign div_zero     = (rd_b_q == 32'd0);

	assign wr_ok   = (32'(aid_q) < 32'(NUM_ARRAYS)) && (32'(eidx_q) < 32'(ARRAY_LENGTH));
	assign wr_addr = MEM_AW'(aid_q) * MEM_AW'(ARRAY_LENGTH) + MEM_AW'(eidx_q);
	assign rd_addr = MEM_AW'(rd_a_q) * MEM_AW'(ARRAY_LENGTH) + MEM_AW'(rd_b_q);

	assign mag_a = rd_a_q[31] ? (32'd0 - rd_a_q) : rd_a_q;
	assign mag_b = rd_b_q[31] ? (32'd0 - rd_b_q) : rd_b_q;
	assign b_big = |rd_b_q[30:5];

	always_comb begin
		case (op_q)
			OP_MUL:  alu_res = rd_a_q * rd_b_q;
			OP_ADD:  alu_res = rd_a_q + rd_b_q;
			OP_SUB:  alu_res = rd_a_q - rd_b_q;
			OP_SHL: begin
				if (rd_b_q[31])
					alu_res = rd_a_q;
				else if (b_big)
					alu_res = 32'd0;
				else
					alu_res = rd_a_q << rd_b_q[4:0];
			end
			OP_SHR: begin
				if (rd_b_q[31])
					alu_res = rd_a_q;
				else if (b_big)
					alu_res = {32{rd_a_q[31]}};
				else
					alu_res = 32'($signed(rd_a_q) >>> rd_b_q[4:0]);
			end
			OP_LT:   alu_res = 32'($signed(rd_a_q) < $signed(rd_b_q));
			OP_LE:   alu_res = 32'($signed(rd_a_q) <= $signed(rd_b_q));
			OP_GT:   alu_res = 32'($signed(rd_a_q) > $signed(rd_b_q));
			OP_GE:   alu_res = 32'($signed(rd_a_q) >= $signed(rd_b_q));
			OP_EQ:   alu_res = 32'(rd_a_q == rd_b_q);
			OP_NE:   alu_res = 32'(rd_a_q != rd_b_q);
			OP_AND:  alu_res = rd_a_q & rd_b_q;
			OP_XOR:  alu_res = rd_a_q ^ rd_b_q;
			OP_OR:   alu_res = rd_a_q | rd_b_q;
			OP_LAND: alu_res = 32'((rd_a_q != 32'd0) && (rd_b_q != 32'd0));
			OP_LOR:  alu_res = 32'((rd_a_q != 32'd0) || (rd_b_q != 32'd0));
			default: alu_res = 32'd0;
		endcase
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh  = {rem_q, quo_q[31]};
	assign diff    = rem_sh - {1'b0, dvs_q};
	assign rem_n   = diff[32] ? rem_sh[31:0] : diff[31:0];
	assign quo_n   = {quo_q[30:0], !diff[32]};
	assign div_res = (op_q == OP_DIV)
		? ((neg_a_q != neg_b_q) ? (32'd0 - quo_n) : quo_n)
		: (neg_a_q ? (32'd0 - rem_n) : rem_n);

	assign err_last = (rd_rb_q && err_q == ERR_NONE) ? ERR_TYPE : err_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				if (opc_q == OPC_APPLY && !op_bad && !sp_lt2)
					state_d = ST_OPRD;
				else
					state_d = ST_FIN;
			end
			ST_OPRD: begin
				if (op_q == OP_SUBSCRIPT)
					state_d = (sub_type_err || sub_idx_err) ? ST_PUSH : ST_MEMRD;
				else if (!val_type_err && !div_zero && (op_q == OP_DIV || op_q == OP_REM))
					state_d = ST_DIV;
				else
					state_d = ST_PUSH;
			end
			ST_MEMRD:  state_d = ST_PUSH;
			ST_DIV:    if (cnt_q == 5'd31) state_d = ST_PUSH;
			ST_PUSH:   state_d = ST_FIN;
			ST_FIN: begin
				if (!last_q)
					state_d = ST_IDLE;
				else if (sp_q == SP_W'(0))
					state_d = ST_OUT;
				else
					state_d = ST_LASTRD;
			end
			ST_LASTRD: state_d = ST_OUT;
			ST_OUT:    if (!out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		out_valid    = (state_q == ST_OUT);
		result_value = out_val_q;
		error_code   = err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q    <= '0;
			err_q   <= ERR_NONE;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && first_token) begin
						sp_q  <= '0;
						err_q <= ERR_NONE;
					end
				end
				ST_DECODE: begin
					case (opc_q)
						OPC_LIT, OPC_REF: begin
							if (sp_full) begin
								if (err_q == ERR_NONE) err_q <= ERR_OVER;
							end else begin
								sp_q <= sp_q + SP_W'(1);
							end
						end
						OPC_APPLY: begin
							if (op_bad) begin
								if (err_q == ERR_NONE) err_q <= ERR_TYPE;
							end else if (sp_lt2) begin
								if (err_q == ERR_NONE) err_q <= ERR_UNDER;
							end else begin
								sp_q <= sp_q - SP_W'(2);
							end
						end
						default: begin
							if (!wr_ok && err_q == ERR_NONE) err_q <= ERR_INDEX;
						end
					endcase
				end
				ST_OPRD: begin
					if (err_q == ERR_NONE) begin
						if (op_q == OP_SUBSCRIPT) begin
							if (sub_type_err)
								err_q <= ERR_TYPE;
							else if (sub_idx_err)
								err_q <= ERR_INDEX;
						end else if (val_type_err) begin
							err_q <= ERR_TYPE;
						end else if ((op_q == OP_DIV || op_q == OP_REM) && div_zero) begin
							err_q <= ERR_DIVZERO;
						end
					end
				end
				ST_PUSH: sp_q <= sp_q + SP_W'(1);
				ST_FIN: begin
					if (last_q && sp_q == SP_W'(0) && err_q == ERR_NONE)
						err_q <= ERR_UNDER;
				end
				ST_LASTRD: begin
					sp_q  <= sp_q - SP_W'(1);
					err_q <= err_last;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			opc_q  <= opcode;
			op_q   <= operator_code;
			lit_q  <= literal_value;
			aid_q  <= array_id;
			eidx_q <= element_index;
			last_q <= last_token;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q  <= stk_val_q[idx_a];
		rd_ra_q <= stk_ref_q[idx_a];
		rd_b_q  <= stk_val_q[idx_b];
		rd_rb_q <= stk_ref_q[idx_b];
		if (state_q == ST_DECODE && !sp_full && (opc_q == OPC_LIT || opc_q == OPC_REF)) begin
			stk_val_q[idx_w] <= (opc_q == OPC_LIT) ? lit_q : 32'(aid_q);
			stk_ref_q[idx_w] <= (opc_q == OPC_REF);
		end else if (state_q == ST_PUSH) begin
			stk_val_q[idx_w] <= res_q;
			stk_ref_q[idx_w] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mem_rd_q <= mem_q[rd_addr];
		if (state_q == ST_DECODE && opc_q == OPC_WRITE && wr_ok)
			mem_q[wr_addr] <= lit_q;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_OPRD: begin
				if (op_q == OP_SUBSCRIPT || val_type_err || div_zero
						&& (op_q == OP_DIV || op_q == OP_REM))
					res_q <= 32'd0;
				else
					res_q <= alu_res;
				rem_q   <= 32'd0;
				quo_q   <= mag_a;
				dvs_q   <= mag_b;
				cnt_q   <= 5'd0;
				neg_a_q <= rd_a_q[31];
				neg_b_q <= rd_b_q[31];
			end
			ST_MEMRD: res_q <= mem_rd_q;
			ST_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) res_q <= div_res;
			end
			ST_FIN:    out_val_q <= 32'd0;
			ST_LASTRD: out_val_q <= (err_last == ERR_NONE) ? rd_b_q : 32'd0;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_err_zero_val: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code != ERR_NONE) |-> (result_value == 32'sd0))
		else $error("nonzero result with error");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == 5'd31) |=> (state_q == ST_PUSH))
		else $error("divider did not finish");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: postfix_stack_evaluator regression
// Drives token streams (directed corner cases, then random well-formed
// expressions with noise) under varying request gaps and output stalls.
// Results are checked against an in-bench stack evaluator.
// ----------------------------------------------------------------------------
module testbench
	import pse_pkg::*;
();

	typedef struct {
		logic signed [31:0] value;
		logic [2:0]         code;
	} outcome_t;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic [4:0]         operator_code;
	logic signed [31:0] literal_value;
	logic [1:0]         array_id;
	logic [7:0]         element_index;
	logic               first_token;
	logic               last_token;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] result_value;
	logic [2:0]         error_code;

	// evaluator state mirrored in the bench
	logic [31:0] stk_val [STACK_DEPTH];
	bit          stk_ref [STACK_DEPTH];
	int          depth;
	logic [2:0]  sticky;
	logic [31:0] mem_val [MEM_DEPTH];
	bit          mem_written [MEM_DEPTH];

	outcome_t result_q[$];
	int       mismatches;
	int       cycles;
	int       idle_pct;
	int       stall_pct;
	int       sent;

	postfix_stack_evaluator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.operator_code (operator_code),
		.literal_value (literal_value),
		.array_id      (array_id),
		.element_index (element_index),
		.first_token   (first_token),
		.last_token    (last_token),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_value  (result_value),
		.error_code    (error_code)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void flag_error(logic [2:0] code);
		if (sticky == ERR_NONE)
			sticky = code;
	endfunction

	function automatic void expect_result(outcome_t o);
		result_q.insert(result_q.size(), o);
	endfunction

	function automatic void stack_push(logic [31:0] v, bit is_ref);
		if (depth >= STACK_DEPTH) begin
			flag_error(ERR_OVER);
			return;
		end
		stk_val[depth] = v;
		stk_ref[depth] = is_ref;
		depth++;
	endfunction

	function automatic logic [31:0] alu(logic [4:0] op, logic [31:0] a, logic [31:0] b);
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		logic [31:0]        ma;
		logic [31:0]        mb;
		logic [31:0]        q;
		sa = a;
		sb = b;
		case (op)
			OP_MUL: return a * b;
			OP_DIV, OP_REM: begin
				if (b == 0) begin
					flag_error(ERR_DIVZERO);
					return 0;
				end
				ma = sa < 0 ? -a : a;
				mb = sb < 0 ? -b : b;
				if (op == OP_DIV) begin
					q = ma / mb;
					return ((sa < 0) != (sb < 0)) ? -q : q;
				end
				q = ma % mb;
				return sa < 0 ? -q : q;
			end
			OP_ADD: return a + b;
			OP_SUB: return a - b;
			OP_SHL: begin
				if (sb < 0) return a;
				if (sb >= 32) return 0;
				return a << sb;
			end
			OP_SHR: begin
				if (sb < 0) return a;
				if (sb >= 32) return {32{a[31]}};
				return sa >>> sb;
			end
			OP_LT:   return {31'b0, sa < sb};
			OP_LE:   return {31'b0, sa <= sb};
			OP_GT:   return {31'b0, sa > sb};
			OP_GE:   return {31'b0, sa >= sb};
			OP_EQ:   return {31'b0, a == b};
			OP_NE:   return {31'b0, a != b};
			OP_AND:  return a & b;
			OP_XOR:  return a ^ b;
			OP_OR:   return a | b;
			OP_LAND: return {31'b0, (a != 0) && (b != 0)};
			default: return {31'b0, (a != 0) || (b != 0)};
		endcase
	endfunction

	function automatic void apply_op(logic [4:0] op);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] res;
		bit          ra;
		bit          rb;
		res = 0;
		if (op > OP_LOR) begin
			flag_error(ERR_TYPE);
			return;
		end
		if (depth < 2) begin
			flag_error(ERR_UNDER);
			return;
		end
		b = stk_val[depth-1];
		rb = stk_ref[depth-1];
		a = stk_val[depth-2];
		ra = stk_ref[depth-2];
		depth -= 2;
		if (op == OP_SUBSCRIPT) begin
			if (!ra || rb)
				flag_error(ERR_TYPE);
			else if (a >= NUM_ARRAYS || b[31] || b >= ARRAY_LENGTH)
				flag_error(ERR_INDEX);
			else
				res = mem_val[a * ARRAY_LENGTH + b];
		end else if (ra || rb) begin
			flag_error(ERR_TYPE);
		end else begin
			res = alu(op, a, b);
		end
		stack_push(res, 1'b0);
	endfunction

	function automatic void evaluate_token(logic [1:0] opc, logic [4:0] op,
			logic [31:0] lit, logic [1:0] arr, logic [7:0] idx, bit first, bit last);
		outcome_t o;
		if (first) begin
			depth = 0;
			sticky = ERR_NONE;
		end
		case (opc)
			OPC_LIT:   stack_push(lit, 1'b0);
			OPC_REF:   stack_push({30'b0, arr}, 1'b1);
			OPC_APPLY: apply_op(op);
			default: begin
				if (arr >= NUM_ARRAYS || idx >= ARRAY_LENGTH) begin
					flag_error(ERR_INDEX);
				end else begin
					mem_val[arr * ARRAY_LENGTH + idx] = lit;
					mem_written[arr * ARRAY_LENGTH + idx] = 1'b1;
				end
			end
		endcase
		if (!last)
			return;
		o.value = 0;
		if (depth == 0) begin
			flag_error(ERR_UNDER);
		end else begin
			depth--;
			if (stk_ref[depth])
				flag_error(ERR_TYPE);
			else
				o.value = stk_val[depth];
		end
		if (sticky != ERR_NONE)
			o.value = 0;
		o.code = sticky;
		expect_result(o);
	endfunction

	// a subscript that would fetch a never-written element is not allowed
	function automatic bit reads_unwritten(logic [4:0] op, bit first);
		logic [31:0] a;
		logic [31:0] b;
		if (op != OP_SUBSCRIPT || first || depth < 2)
			return 1'b0;
		a = stk_val[depth-2];
		b = stk_val[depth-1];
		if (!stk_ref[depth-2] || stk_ref[depth-1] || a >= NUM_ARRAYS || b[31]
				|| b >= ARRAY_LENGTH)
			return 1'b0;
		return !mem_written[a * ARRAY_LENGTH + b];
	endfunction

	task automatic send_token(logic [1:0] opc, logic [4:0] op, logic [31:0] lit,
			logic [1:0] arr, logic [7:0] idx, bit first, bit last);
		in_valid      <= 1'b1;
		opcode        <= opc;
		operator_code <= op;
		literal_value <= lit;
		array_id      <= arr;
		element_index <= idx;
		first_token   <= first;
		last_token    <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		evaluate_token(opc, op, lit, arr, idx, first, last);
		sent++;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic eval_pair(logic [31:0] a, logic [31:0] b, logic [4:0] op);
		send_token(OPC_LIT, OP_ADD, a, 0, 0, 1, 0);
		send_token(OPC_LIT, OP_ADD, b, 0, 0, 0, 0);
		send_token(OPC_APPLY, op, 0, 0, 0, 0, 1);
	endtask

	task automatic test_array_access();
		send_token(OPC_WRITE, OP_ADD, 32'h7fffffff, 0, 0, 1, 0);
		send_token(OPC_WRITE, OP_ADD, 32'h80000000, 3, 255, 0, 0);
		send_token(OPC_REF, OP_ADD, 0, 0, 0, 0, 0);
		send_token(OPC_LIT, OP_ADD, 0, 0, 0, 0, 0);
		send_token(OPC_APPLY, OP_SUBSCRIPT, 0, 0, 0, 0, 1);
		send_token(OPC_REF, OP_ADD, 0, 3, 0, 1, 0);
		send_token(OPC_LIT, OP_ADD, 255, 0, 0, 0, 0);
		send_token(OPC_APPLY, OP_SUBSCRIPT, 0, 0, 0, 0, 1);
		send_token(OPC_REF, OP_ADD, 0, 1, 0, 1, 0);
		send_token(OPC_LIT, OP_ADD, -1, 0, 0, 0, 0);
		send_token(OPC_APPLY, OP_SUBSCRIPT, 0, 0, 0, 0, 1);
		send_token(OPC_REF, OP_ADD, 0, 2, 0, 1, 0);
		send_token(OPC_LIT, OP_ADD, 256, 0, 0, 0, 0);
		send_token(OPC_APPLY, OP_SUBSCRIPT, 0, 0, 0, 0, 1);
	endtask

	task automatic test_operators();
		for (int op = OP_MUL; op <= OP_LOR; op++)
			eval_pair(-100, 7, 5'(op));
		eval_pair(32'h80000000, -1, OP_DIV);
		eval_pair(32'h80000000, -1, OP_REM);
		eval_pair(32'h7fffffff, 32'h7fffffff, OP_MUL);
		eval_pair(-8, 32, OP_SHL);
		eval_pair(-8, 40, OP_SHR);
		eval_pair(-8, -3, OP_SHR);
		eval_pair(32'h7fffffff, 1, OP_ADD);
	endtask

	task automatic test_error_cases();
		eval_pair(5, 0, OP_DIV);
		eval_pair(5, 0, OP_REM);
		send_token(OPC_LIT, OP_ADD, 1, 0, 0, 1, 0);
		send_token(OPC_APPLY, OP_ADD, 0, 0, 0, 0, 1);
		send_token(OPC_LIT, OP_ADD, 1, 0, 0, 1, 0);
		send_token(OPC_LIT, OP_ADD, 2, 0, 0, 0, 0);
		send_token(OPC_APPLY, 5'd31, 0, 0, 0, 0, 1);
		send_token(OPC_REF, OP_ADD, 0, 1, 0, 1, 0);
		send_token(OPC_LIT, OP_ADD, 2, 0, 0, 0, 0);
		send_token(OPC_APPLY, OP_ADD, 0, 0, 0, 0, 1);
		eval_pair(3, 4, OP_SUBSCRIPT);
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_token(OPC_LIT, OP_ADD, i, 0, 0, i == 0, i == STACK_DEPTH);
		send_token(OPC_WRITE, OP_ADD, 9, 2, 8'haa, 1, 1);
		send_token(OPC_REF, OP_ADD, 0, 2, 0, 1, 1);
		// first error wins over a later underflow
		eval_pair(1, 0, OP_DIV);
		send_token(OPC_APPLY, OP_ADD, 0, 0, 0, 0, 1);
		send_token(OPC_LIT, OP_ADD, 77, 0, 0, 1, 0);
		send_token(OPC_LIT, OP_ADD, 78, 0, 0, 0, 1);
		send_token(OPC_LIT, OP_ADD, 0, 0, 0, 0, 1);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom_range(15);
			1: begin
				case ($urandom_range(4))
					0: return 0;
					1: return 1;
					2: return 32'hffffffff;
					3: return 32'h80000000;
					default: return 32'h7fffffff;
				endcase
			end
			2: return $urandom_range(80) - 40;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_expression();
		int          len;
		int          eff;
		int          r;
		bit          first;
		bit          last;
		bit          overfill;
		logic [4:0]  op;
		logic [7:0]  idx;
		overfill = $urandom_range(19) == 0;
		len = overfill ? STACK_DEPTH + 2 : $urandom_range(1, 12);
		for (int i = 0; i < len; i++) begin
			first = (i == 0) && ($urandom_range(9) != 0);
			last = (i == len - 1);
			eff = first ? 0 : depth;
			r = $urandom_range(99);
			if (overfill) begin
				send_token(OPC_LIT, 5'($urandom), rand_word(), 2'($urandom),
					8'($urandom), first, last);
			end else if (r < 8) begin
				idx = $urandom_range(9) < 7 ? 8'($urandom_range(15))
					: 8'($urandom_range(255));
				send_token(OPC_WRITE, 5'($urandom), rand_word(), 2'($urandom), idx,
					first, last);
			end else if (eff < 2 || r < 45) begin
				if ($urandom_range(99) < 18)
					send_token(OPC_REF, 5'($urandom), $urandom, 2'($urandom),
						8'($urandom), first, last);
				else
					send_token(OPC_LIT, 5'($urandom), rand_word(), 2'($urandom),
						8'($urandom), first, last);
			end else begin
				if ($urandom_range(99) < 4)
					op = 5'($urandom_range(31, 19));
				else if ($urandom_range(99) < 15)
					op = OP_SUBSCRIPT;
				else
					op = 5'($urandom_range(OP_LOR));
				if (reads_unwritten(op, first))
					op = OP_ADD;
				send_token(OPC_APPLY, op, $urandom, 2'($urandom), 8'($urandom),
					first, last);
			end
		end
	endtask

	task automatic test_random(int count, int idle, int stall);
		int start;
		idle_pct = idle;
		stall_pct = stall;
		start = sent;
		while (sent - start < count)
			random_expression();
	endtask

	always @(posedge clk) begin
		out_stall <= $urandom_range(99) < stall_pct;
	end

	always @(posedge clk) begin
		outcome_t exp_o;
		if (out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result value=%0d code=%0d", $time,
					result_value, error_code);
				mismatches++;
			end else begin
				exp_o = result_q.pop_front();
				if (result_value !== exp_o.value) begin
					$display("%0t: result_value expected %0d actual %0d", $time,
						exp_o.value, result_value);
					mismatches++;
				end
				if (error_code !== exp_o.code) begin
					$display("%0t: error_code expected %0d actual %0d", $time,
						exp_o.code, error_code);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("postfix_stack_evaluator regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OPC_LIT;
		operator_code = OP_SUBSCRIPT;
		literal_value = 0;
		array_id = 0;
		element_index = 0;
		first_token = 1'b0;
		last_token = 1'b0;
		out_stall = 1'b0;
		mismatches = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		sent = 0;
		depth = 0;
		sticky = ERR_NONE;
		foreach (mem_written[i])
			mem_written[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_array_access();
		test_operators();
		test_error_cases();
		test_random(105, 0, 0);
		test_random(105, 81, 0);
		test_random(105, 0, 81);
		test_random(105, 35, 35);
		in_valid <= 1'b0;

		wait (result_q.size() == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && result_q.size() == 0)
			$display("postfix_stack_evaluator regression: pass");
		else
			$display("postfix_stack_evaluator regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/pse_pkg.sv
rtl/postfix_stack_evaluator.sv
dv/testbench.sv
